### src/cadf_pkg.sv
// shared constants for the cascaded average filter
`timescale 1ns / 1ps

package cadf_pkg;

  // fixed field widths of the item ports
  localparam int CHANNEL_BITS = 2;
  localparam int SAMPLE_BITS  = 12;
  localparam int VALUE_BITS   = 12;

  // four raw samples per item, averaged by a shift
  localparam int RAW_COUNT = 4;
  localparam int RAW_SHIFT = $clog2(RAW_COUNT);
  localparam int RAW_SUM_BITS = SAMPLE_BITS + RAW_SHIFT;

  // defaults for the top level parameters
  localparam int DEF_CHANNELS      = 4;
  localparam int DEF_HISTORY_DEPTH = 4;

endpackage

### src/cadf_avg.sv
// shifts a value into one history row and takes the floor average of the new row
`timescale 1ns / 1ps

module cadf_avg #(
  parameter int HISTORY_DEPTH = cadf_pkg::DEF_HISTORY_DEPTH
) (
  input  logic [HISTORY_DEPTH-1:0][cadf_pkg::SAMPLE_BITS-1:0] row_i,
  input  logic [cadf_pkg::SAMPLE_BITS-1:0]                    value_i,
  output logic [HISTORY_DEPTH-1:0][cadf_pkg::SAMPLE_BITS-1:0] row_o,
  output logic [cadf_pkg::SAMPLE_BITS-1:0]                    avg_o
);

  localparam int SHIFT     = $clog2(HISTORY_DEPTH);
  localparam int SUM_BITS  = cadf_pkg::SAMPLE_BITS + SHIFT;
  localparam bit IS_POW2   = ((1 << SHIFT) == HISTORY_DEPTH);
  // reciprocal for exact floor division of a SUM_BITS value
  localparam int RECIP_K   = SUM_BITS + SHIFT;
  localparam int MULT_BITS = SUM_BITS + 1;
  localparam longint unsigned MULT_FULL =
    ((64'd1 << RECIP_K) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [MULT_BITS-1:0] MULT = MULT_BITS'(MULT_FULL);

  logic [SUM_BITS-1:0] sum;

  always_comb begin
    row_o[0] = value_i;
    for (int k = 1; k < HISTORY_DEPTH; k++) begin
      row_o[k] = row_i[k-1];
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      sum = sum + SUM_BITS'(row_o[k]);
    end
  end

  generate
    if (IS_POW2) begin : g_shift
      logic [SUM_BITS-1:0] quot;
      assign quot  = sum >> SHIFT;
      assign avg_o = quot[cadf_pkg::SAMPLE_BITS-1:0];
    end else begin : g_recip
      logic [SUM_BITS+MULT_BITS-1:0] prod;
      logic [SUM_BITS+MULT_BITS-1:0] quot;
      assign prod  = (SUM_BITS+MULT_BITS)'(sum) * (SUM_BITS+MULT_BITS)'(MULT);
      assign quot  = prod >> RECIP_K;
      assign avg_o = quot[cadf_pkg::SAMPLE_BITS-1:0];
    end
  endgenerate

endmodule

### src/cadf_hist.sv
// per-channel history rows, cleared at reset, one row read and written per cycle
`timescale 1ns / 1ps

module cadf_hist #(
  parameter int CHANNELS      = cadf_pkg::DEF_CHANNELS,
  parameter int HISTORY_DEPTH = cadf_pkg::DEF_HISTORY_DEPTH,
  parameter int CH_IDX_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic [CH_IDX_BITS-1:0]                               ch_idx,
  output logic [HISTORY_DEPTH-1:0][cadf_pkg::SAMPLE_BITS-1:0]  rd_row,
  input  logic                                                 wr_en,
  input  logic [HISTORY_DEPTH-1:0][cadf_pkg::SAMPLE_BITS-1:0]  wr_row
);

  logic [CHANNELS-1:0][HISTORY_DEPTH-1:0][cadf_pkg::SAMPLE_BITS-1:0] hist_r;

  assign rd_row = hist_r[ch_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (wr_en) begin
      hist_r[ch_idx] <= wr_row;
    end
  end

endmodule

### src/cascaded_average_adc_filter_core.sv
// top level of the cascaded moving-average filter for a multi-channel adc stream
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_channel, in_sample_a..d
//   out_     output     out_valid/out_stall out_channel, out_filtered_value
//
// one item per cycle sustained while out_stall is low; an accepted item passes
// through the input register, then the result register, to the output
// both history stages of an in-range channel are read and rewritten in the
// single cycle an item moves from the input register to the result register
// synchronous active-low reset clears both history stores and all valid flags
// in_stall rises only when both registers hold items and out_stall is high
`timescale 1ns / 1ps

module cascaded_average_adc_filter_core #(
  parameter int CHANNELS      = cadf_pkg::DEF_CHANNELS,
  parameter int HISTORY_DEPTH = cadf_pkg::DEF_HISTORY_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cadf_pkg::CHANNEL_BITS-1:0]    in_channel,
  input  logic [cadf_pkg::SAMPLE_BITS-1:0]     in_sample_a,
  input  logic [cadf_pkg::SAMPLE_BITS-1:0]     in_sample_b,
  input  logic [cadf_pkg::SAMPLE_BITS-1:0]     in_sample_c,
  input  logic [cadf_pkg::SAMPLE_BITS-1:0]     in_sample_d,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cadf_pkg::CHANNEL_BITS-1:0]    out_channel,
  output logic [cadf_pkg::VALUE_BITS-1:0]      out_filtered_value
);

  localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // input register
  logic                               in_valid_r;
  logic [cadf_pkg::CHANNEL_BITS-1:0]  in_channel_r;
  logic [cadf_pkg::SAMPLE_BITS-1:0]   in_sample_a_r;
  logic [cadf_pkg::SAMPLE_BITS-1:0]   in_sample_b_r;
  logic [cadf_pkg::SAMPLE_BITS-1:0]   in_sample_c_r;
  logic [cadf_pkg::SAMPLE_BITS-1:0]   in_sample_d_r;
  logic                               in_valid_nxt;

  // result register
  logic                               out_valid_r;
  logic [cadf_pkg::CHANNEL_BITS-1:0]  out_channel_r;
  logic [cadf_pkg::VALUE_BITS-1:0]    out_value_r;

  logic                               in_accept;
  logic                               advance;
  logic                               ch_ok;
  logic                               hist_wr;
  logic [CH_IDX_BITS-1:0]             ch_idx;
  logic [cadf_pkg::RAW_SUM_BITS-1:0]  raw_sum;
  logic [cadf_pkg::RAW_SUM_BITS-1:0]  raw_quot;
  logic [cadf_pkg::SAMPLE_BITS-1:0]   raw_avg;
  logic [cadf_pkg::SAMPLE_BITS-1:0]   stage1_avg;
  logic [cadf_pkg::SAMPLE_BITS-1:0]   stage2_avg;
  logic [cadf_pkg::VALUE_BITS-1:0]    result_value;

  logic [HISTORY_DEPTH-1:0][cadf_pkg::SAMPLE_BITS-1:0] first_row;
  logic [HISTORY_DEPTH-1:0][cadf_pkg::SAMPLE_BITS-1:0] first_row_new;
  logic [HISTORY_DEPTH-1:0][cadf_pkg::SAMPLE_BITS-1:0] second_row;
  logic [HISTORY_DEPTH-1:0][cadf_pkg::SAMPLE_BITS-1:0] second_row_new;

  // result register frees up when empty or when its item is taken
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // channels past the store leave history alone and give a zero value
  assign ch_ok   = (32'(in_channel_r) < CHANNELS);
  assign ch_idx  = ch_ok ? CH_IDX_BITS'(in_channel_r) : '0;
  assign hist_wr = in_valid_r && advance && ch_ok;

  assign raw_sum = cadf_pkg::RAW_SUM_BITS'(in_sample_a_r)
                 + cadf_pkg::RAW_SUM_BITS'(in_sample_b_r)
                 + cadf_pkg::RAW_SUM_BITS'(in_sample_c_r)
                 + cadf_pkg::RAW_SUM_BITS'(in_sample_d_r);
  assign raw_quot = raw_sum >> cadf_pkg::RAW_SHIFT;
  assign raw_avg  = raw_quot[cadf_pkg::SAMPLE_BITS-1:0];

  cadf_hist #(
    .CHANNELS      (CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .CH_IDX_BITS   (CH_IDX_BITS)
  ) u_first_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ch_idx (ch_idx),
    .rd_row (first_row),
    .wr_en  (hist_wr),
    .wr_row (first_row_new)
  );

  cadf_avg #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_first_avg (
    .row_i   (first_row),
    .value_i (raw_avg),
    .row_o   (first_row_new),
    .avg_o   (stage1_avg)
  );

  cadf_hist #(
    .CHANNELS      (CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .CH_IDX_BITS   (CH_IDX_BITS)
  ) u_second_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .ch_idx (ch_idx),
    .rd_row (second_row),
    .wr_en  (hist_wr),
    .wr_row (second_row_new)
  );

  cadf_avg #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_second_avg (
    .row_i   (second_row),
    .value_i (stage1_avg),
    .row_o   (second_row_new),
    .avg_o   (stage2_avg)
  );

  assign result_value = ch_ok ? cadf_pkg::VALUE_BITS'(stage2_avg) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_channel_r  <= in_channel;
      in_sample_a_r <= in_sample_a;
      in_sample_b_r <= in_sample_b;
      in_sample_c_r <= in_sample_c;
      in_sample_d_r <= in_sample_d;
    end
    if (advance && in_valid_r) begin
      out_channel_r <= in_channel_r;
      out_value_r   <= result_value;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_channel_r;
  assign out_filtered_value = out_value_r;

endmodule
